// ----- hdl/kdr_pkg.sv -----
// ----------------------------------------------------------------------------
// kdr_pkg: shared definitions of the key debounce / auto-repeat block
// key and page counts, field widths, codes and register reset values
// ----------------------------------------------------------------------------
`default_nettype none

package kdr_pkg;

  localparam int KEY_COUNT  = 5;
  localparam int PAGE_COUNT = 4;

  localparam int KEY_W   = 3;
  localparam int TICK_W  = 32;
  localparam int THR_W   = 16;
  localparam int PAGE_W  = 4;
  localparam int SP_W    = 10;
  localparam int STEP_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W  = 2;

  // mode codes carried in tuser
  localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLL    = 2'd2;

  // key codes
  localparam logic [KEY_W-1:0] KEY_UP    = 3'd0;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd1;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 3'd2;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 3'd3;
  localparam logic [KEY_W-1:0] KEY_LAST  = KEY_W'(KEY_COUNT - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SP_MAX   = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0]  RST_DEBOUNCE = 16'd20;
  localparam logic [THR_W-1:0]  RST_DELAY    = 16'd500;
  localparam logic [THR_W-1:0]  RST_INTERVAL = 16'd10;
  localparam logic [STEP_W-1:0] RST_STEP     = 8'd1;
  localparam logic [SP_W-1:0]   RST_SP_MAX   = 10'd240;

endpackage

`default_nettype wire

// ----- hdl/kdr_cmp.sv -----
// ----------------------------------------------------------------------------
// kdr_cmp: shared elapsed-time compare unit
// computes (now - stamp) mod 2^32 and checks it against a 16-bit threshold
// ----------------------------------------------------------------------------
`default_nettype none

module kdr_cmp
  import kdr_pkg::*;
(
  input  wire logic [TICK_W-1:0] now,
  input  wire logic [TICK_W-1:0] stamp,
  input  wire logic [THR_W-1:0]  thr,
  output logic                   elapsed_ok
);

  logic [TICK_W-1:0] diff;

  // wrapping difference, then unsigned compare against zero-extended limit
  assign diff       = now - stamp;
  assign elapsed_ok = (diff >= {{(TICK_W-THR_W){1'b0}}, thr});

endmodule

`default_nettype wire

// ----- hdl/key_debounce_repeat_setpoint.sv -----
// ----------------------------------------------------------------------------
// key_debounce_repeat_setpoint: key debounce with auto-repeat, page and setpoints
// five keys step a display page and two clamped setpoints (0.1 V units)
// ----------------------------------------------------------------------------
// usage:
//   in_*   stream channel, one transaction per item; in_tuser is the mode
//          (press, release, poll), in_tdata holds key id, tick and the
//          released-key pin levels of a poll
//   out_*  stream channel, exactly one result transaction per input item:
//          page, both setpoints, page-changed and target-updated flags
//   cfg_*  plain write port for debounce time, repeat delay, repeat
//          interval, step size and setpoint limit; write only while idle
// timing:
//   one item at a time; a single elapsed-time compare unit is stepped by
//   the sequencer, one compare per cycle. an event runs its debounce check,
//   then the press action if it runs one, then the result load; an ignored
//   key id or the unused mode goes straight to the load; a poll walks keys
//   0..4, each held key through held check, delay, interval, debounce and
//   press action as far as its checks pass, then loads the result. the next
//   item is accepted only after the load
// stall: the finished result sits in the output register; the next item is
//   accepted meanwhile and waits before its own result until that slot frees
// reset: synchronous, active low; all key state, page and setpoints clear to
//   zero and the registers take their default values
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_repeat_setpoint
  import kdr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [39:0]          in_tdata,  // key_id[2:0], tick[34:3], released_keys[39:35]
  input  wire logic [MODE_W-1:0]    in_tuser,  // mode[1:0]
  // result channel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata, // page[3:0], setpoint_one[13:4],
                                               // setpoint_two[23:14], page_changed[24],
                                               // target_updated[25], zero fill[31:26]
  // configuration port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EV_DEB,   // event debounce check
    S_POLL,     // poll: held / released check of one key
    S_DLY,      // poll: repeat delay reached
    S_INT,      // poll: repeat interval reached
    S_PDEB,     // poll: repeat debounce
    S_ACT,      // press action of the current key
    S_FIN       // load result when output slot free
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [THR_W-1:0]  debounce_r, delay_r, interval_r;
  logic [STEP_W-1:0] step_r;
  logic [SP_W-1:0]   sp_max_r;

  // per-key state
  logic [KEY_COUNT-1:0] held_r, held_nxt;
  logic [TICK_W-1:0]    press_time_r [KEY_COUNT];
  logic [TICK_W-1:0]    last_event_r [KEY_COUNT];
  logic [TICK_W-1:0]    last_rep_r   [KEY_COUNT];

  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [SP_W-1:0]   sp_r [2];
  logic [SP_W-1:0]   sp_new;

  // latched item
  logic [MODE_W-1:0]    mode_r;
  logic [KEY_W-1:0]     idx_r, idx_nxt;
  logic [TICK_W-1:0]    tick_r;
  logic [KEY_COUNT-1:0] rel_r;

  logic flag_page_r, flag_page_nxt;
  logic flag_target_r, flag_target_nxt;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  // shared compare unit operands
  logic [TICK_W-1:0] cmp_stamp;
  logic [THR_W-1:0]  cmp_thr;
  logic              cmp_ok;

  // per-cycle write strobes into the key arrays and the setpoints
  logic upd_event, upd_press, upd_rep_now, upd_rep_zero, upd_sp;

  kdr_cmp u_cmp (
    .now        (tick_r),
    .stamp      (cmp_stamp),
    .thr        (cmp_thr),
    .elapsed_ok (cmp_ok)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // operand select for the compare unit
  always_comb begin
    unique case (state_r)
      S_DLY: begin
        cmp_stamp = press_time_r[idx_r];
        cmp_thr   = delay_r;
      end
      S_INT: begin
        cmp_stamp = last_rep_r[idx_r];
        cmp_thr   = interval_r;
      end
      default: begin
        cmp_stamp = last_event_r[idx_r];
        cmp_thr   = debounce_r;
      end
    endcase
  end

  // setpoint step of the current page, saturating to 0..max
  logic [SP_W-1:0] sp_cur;
  logic [SP_W:0]   sp_sum;
  logic [SP_W-1:0] sp_dif;
  logic [SP_W-1:0] step_ext;

  assign sp_cur   = sp_r[page_r[0]];
  assign step_ext = {{(SP_W-STEP_W){1'b0}}, step_r};
  assign sp_sum   = {1'b0, sp_cur} + {1'b0, step_ext};
  assign sp_dif   = sp_cur - step_ext;

  always_comb begin
    if (idx_r == KEY_UP) begin
      sp_new = (sp_sum > {1'b0, sp_max_r}) ? sp_max_r : sp_sum[SP_W-1:0];
    end else if (sp_cur < step_ext) begin
      sp_new = '0;
    end else begin
      sp_new = (sp_dif > sp_max_r) ? sp_max_r : sp_dif;
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    held_nxt        = held_r;
    page_nxt        = page_r;
    flag_page_nxt   = flag_page_r;
    flag_target_nxt = flag_target_r;
    upd_event       = 1'b0;
    upd_press       = 1'b0;
    upd_rep_now     = 1'b0;
    upd_rep_zero    = 1'b0;
    upd_sp          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          flag_page_nxt   = 1'b0;
          flag_target_nxt = 1'b0;
          if ((in_tuser == MODE_PRESS || in_tuser == MODE_RELEASE) &&
              in_tdata[2:0] <= KEY_LAST) begin
            idx_nxt   = in_tdata[2:0];
            state_nxt = S_EV_DEB;
          end else if (in_tuser == MODE_POLL) begin
            idx_nxt   = '0;
            state_nxt = S_POLL;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_EV_DEB: begin
        state_nxt = S_FIN;
        if (cmp_ok) begin
          upd_event = 1'b1;
          if (mode_r == MODE_PRESS) begin
            if (!held_r[idx_r]) begin
              held_nxt[idx_r] = 1'b1;
              upd_press       = 1'b1;
              upd_rep_now     = 1'b1;
              state_nxt       = S_ACT;
            end
          end else begin
            held_nxt[idx_r] = 1'b0;
            upd_rep_zero    = 1'b1;
          end
        end
      end

      S_POLL: begin
        if (held_r[idx_r] && !rel_r[idx_r]) begin
          state_nxt = S_DLY;
        end else begin
          // a held key whose pin reads released drops out, nothing else
          held_nxt[idx_r] = 1'b0;
          if (idx_r == KEY_LAST) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_DLY, S_INT: begin
        if (cmp_ok) begin
          state_nxt = (state_r == S_DLY) ? S_INT : S_PDEB;
        end else if (idx_r == KEY_LAST) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_POLL;
        end
      end

      S_PDEB: begin
        upd_rep_now = 1'b1;
        if (cmp_ok) begin
          upd_event = 1'b1;
          state_nxt = S_ACT;
        end else if (idx_r == KEY_LAST) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_POLL;
        end
      end

      S_ACT: begin
        if (idx_r == KEY_LEFT || idx_r == KEY_RIGHT) begin
          if (idx_r == KEY_RIGHT) begin
            page_nxt = (page_r == PAGE_W'(PAGE_COUNT - 1)) ? '0 : page_r + 1'b1;
          end else begin
            page_nxt = (page_r == '0) ? PAGE_W'(PAGE_COUNT - 1) : page_r - 1'b1;
          end
          if (page_nxt != page_r) begin
            flag_page_nxt = 1'b1;
          end
        end else if (idx_r == KEY_UP || idx_r == KEY_DOWN) begin
          // pages other than the two setpoint pages still report the press
          upd_sp          = (page_r < PAGE_W'(2));
          flag_target_nxt = 1'b1;
        end
        if (mode_r != MODE_POLL || idx_r == KEY_LAST) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_POLL;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      held_r        <= '0;
      page_r        <= '0;
      sp_r[0]       <= '0;
      sp_r[1]       <= '0;
      flag_page_r   <= 1'b0;
      flag_target_r <= 1'b0;
      out_valid_r   <= 1'b0;
      debounce_r    <= RST_DEBOUNCE;
      delay_r       <= RST_DELAY;
      interval_r    <= RST_INTERVAL;
      step_r        <= RST_STEP;
      sp_max_r      <= RST_SP_MAX;
      for (int k = 0; k < KEY_COUNT; k++) begin
        press_time_r[k] <= '0;
        last_event_r[k] <= '0;
        last_rep_r[k]   <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      held_r        <= held_nxt;
      page_r        <= page_nxt;
      flag_page_r   <= flag_page_nxt;
      flag_target_r <= flag_target_nxt;

      if (upd_sp) begin
        sp_r[page_r[0]] <= sp_new;
      end
      if (upd_event) begin
        last_event_r[idx_r] <= tick_r;
      end
      if (upd_press) begin
        press_time_r[idx_r] <= tick_r;
      end
      if (upd_rep_now) begin
        last_rep_r[idx_r] <= tick_r;
      end else if (upd_rep_zero) begin
        last_rep_r[idx_r] <= '0;
      end

      // output slot: freed by the receiver, refilled at the end of an item
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEBOUNCE: debounce_r <= cfg_wdata;
          REG_DELAY:    delay_r    <= cfg_wdata;
          REG_INTERVAL: interval_r <= cfg_wdata;
          REG_STEP:     step_r     <= cfg_wdata[STEP_W-1:0];
          REG_SP_MAX:   sp_max_r   <= cfg_wdata[SP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers: latched item and result word
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      mode_r <= in_tuser;
      tick_r <= in_tdata[34:3];
      rel_r  <= in_tdata[39:35];
    end
    if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
      out_data_r <= {6'd0, flag_target_r, flag_page_r, sp_r[1], sp_r[0], page_r};
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // key walk never leaves the key range
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= KEY_LAST)
    else $error("key index out of range");

  // page stays inside the page count
  a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    page_r < PAGE_W'(PAGE_COUNT))
    else $error("page out of range");

  // an accepted item keeps the input side busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // setpoints move only during a press action
  a_sp_only_act: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ACT) |=> ($stable(sp_r[0]) && $stable(sp_r[1])))
    else $error("setpoint changed outside press action");

  // a pending result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
